// ----- hdl/idq_pkg.sv -----
// shared constants, codes and control types for the indexed deque
package idq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    // pop back can leave the iterator far past the count, so keep it wide
    localparam int ITER_W     = 32;
    localparam int OPCODE_W   = 3;
    localparam int STATUS_W   = 3;
    localparam int INDEX_W    = 6;

    // iterator position before the first element
    localparam logic [ITER_W-1:0] ITER_NONE = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_INDEX = 3'd4,
        OP_ITER_RESET = 3'd5,
        OP_ITER_NEXT  = 3'd6
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_FULL  = 3'd2,
        ST_RANGE = 3'd3,
        ST_END   = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CTRL_IDLE = 1'b0,
        CTRL_READ = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic exec;      // transaction accepted, update queue state
        logic load_res;  // load a result without element data
        logic load_mem;  // load a result from the memory read register
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_read; // accepted operation returns a stored element
    } dp_status_t;

endpackage

// ----- hdl/idq_if.sv -----
// request and response channel interfaces of the indexed deque
interface idq_req_if;
    import idq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [DATA_WIDTH-1:0] element_value;
    logic [INDEX_W-1:0]    element_index;

    modport source (output valid, output opcode, output element_value,
                    output element_index, input ready);
    modport sink   (input valid, input opcode, input element_value,
                    input element_index, output ready);
endinterface

interface idq_rsp_if;
    import idq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] read_data;
    logic                  data_valid;
    logic [STATUS_W-1:0]   status;
    logic [CNT_W-1:0]      element_count;

    modport source (output valid, output read_data, output data_valid,
                    output status, output element_count, input ready);
    modport sink   (input valid, input read_data, input data_valid,
                    input status, input element_count, output ready);
endinterface

// ----- hdl/indexed_deque_with_iterator_core.sv -----
// top level of the indexed deque with iterator
// Bounded double-ended queue of 64 words of 32 bits in a ring buffer, with
// indexed read and one forward iterator. Each request transaction gives
// exactly one response transaction. Push, pop, iterator reset, no-op and
// any operation that fails (full, empty, index out of range, iterator at
// end) load their result into the output register on acceptance; read
// index and a successful iterator next take their element from the
// registered read port of the element memory, and hold off the next
// request until that read is loaded. One operation is in flight at a time;
// a request is taken only while the output register is empty or its
// waiting response drains at the same edge. Store entries hold no defined
// value until written; only stored elements are ever returned.
module indexed_deque_with_iterator_core
    import idq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    idq_req_if.sink  req,
    idq_rsp_if.source rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    idq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    idq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (req.opcode),
        .element_value (req.element_value),
        .element_index (req.element_index),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .read_data     (rsp.read_data),
        .data_valid    (rsp.data_valid),
        .status        (rsp.status),
        .element_count (rsp.element_count)
    );

    // a memory read always completes in the following cycle
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && dp_status.need_read |=> cmd.load_mem)
        else $error("memory read result not loaded after read transaction");

    // no new transaction while a read is pending
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_mem |-> !req.ready)
        else $error("request accepted during pending read");

    // returned elements always carry ok status
    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data_valid |-> rsp.status == ST_OK)
        else $error("returned element with error status");

    // count never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.element_count <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

endmodule

// ----- hdl/idq_ctrl.sv -----
// controller: operation sequencing and output slot handshake
module idq_ctrl
    import idq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTRL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        req_ready    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_res = 1'b0;
        cmd.load_mem = 1'b0;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                // output slot is free or drains at this edge
                req_ready = !out_valid_reg || rsp_ready;
                if (req_valid && req_ready)
                begin
                    cmd.exec = 1'b1;
                    if (dp_status.need_read)
                        state_next = CTRL_READ;
                    else
                        cmd.load_res = 1'b1;
                end
            end
            CTRL_READ:
            begin
                cmd.load_mem = 1'b1;
                state_next   = CTRL_IDLE;
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase

        if (cmd.load_res || cmd.load_mem)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

endmodule

// ----- hdl/idq_datapath.sv -----
// datapath: element memory, head, count, iterator and result register
module idq_datapath
    import idq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [OPCODE_W-1:0]   opcode,
    input  logic [DATA_WIDTH-1:0] element_value,
    input  logic [INDEX_W-1:0]    element_index,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            dp_status,
    output logic [DATA_WIDTH-1:0] read_data,
    output logic                  data_valid,
    output logic [STATUS_W-1:0]   status,
    output logic [CNT_W-1:0]      element_count
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    logic [DATA_WIDTH-1:0] read_data_reg;
    logic                  data_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [CNT_W-1:0]      element_count_reg;

    opcode_t           op;
    status_t           res_status;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              need_read;
    logic [ITER_W-1:0] iter_inc;
    logic [ITER_W-1:0] count_ext;

    assign op        = opcode_t'(opcode);
    assign iter_inc  = iter_reg + ITER_W'(1);
    assign count_ext = ITER_W'(count_reg);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        iter_next  = iter_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        rd_addr    = head_reg;
        need_read  = 1'b0;
        res_status = ST_OK;
        unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (count_reg == CNT_W'(DEPTH))
                    res_status = ST_FULL;
                else if (op == OP_PUSH_FRONT || count_reg == '0)
                begin
                    // push back into an empty queue behaves as push front
                    head_next  = head_reg - ADDR_W'(1);
                    wr_en      = 1'b1;
                    wr_addr    = head_reg - ADDR_W'(1);
                    count_next = count_reg + CNT_W'(1);
                    if (iter_reg != ITER_NONE)
                        iter_next = iter_inc;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg + count_reg[ADDR_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (count_reg == '0)
                    res_status = ST_EMPTY;
                else if (count_reg == CNT_W'(1))
                begin
                    head_next  = '0;
                    count_next = '0;
                    iter_next  = ITER_NONE;
                end
                else
                begin
                    head_next  = head_reg + ADDR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    if (iter_reg != ITER_NONE)
                        iter_next = iter_reg - ITER_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (count_reg == '0)
                    res_status = ST_EMPTY;
                else if (count_reg == CNT_W'(1))
                begin
                    head_next  = '0;
                    count_next = '0;
                    iter_next  = ITER_NONE;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    // iterator on the removed tail element goes back to before first
                    if (iter_reg == count_ext - ITER_W'(1))
                        iter_next = ITER_NONE;
                end
            end
            OP_READ_INDEX:
            begin
                if ({1'b0, element_index} >= count_reg)
                    res_status = ST_RANGE;
                else
                begin
                    rd_addr   = head_reg + element_index;
                    need_read = 1'b1;
                end
            end
            OP_ITER_RESET:
            begin
                iter_next = ITER_NONE;
            end
            OP_ITER_NEXT:
            begin
                if ($signed(iter_inc) >= $signed(count_ext))
                begin
                    iter_next  = count_ext;
                    res_status = ST_END;
                end
                else
                begin
                    iter_next = iter_inc;
                    rd_addr   = head_reg + iter_inc[ADDR_W-1:0];
                    need_read = 1'b1;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign dp_status.need_read = need_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            iter_reg  <= ITER_NONE;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
            mem[wr_addr] <= element_value;
        if (cmd.exec)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            read_data_reg     <= '0;
            data_valid_reg    <= 1'b0;
            status_reg        <= res_status;
            element_count_reg <= count_next;
        end
        else if (cmd.load_mem)
        begin
            // reads leave the count unchanged
            read_data_reg     <= rdata_reg;
            data_valid_reg    <= 1'b1;
            status_reg        <= ST_OK;
            element_count_reg <= count_reg;
        end
    end

    assign read_data     = read_data_reg;
    assign data_valid    = data_valid_reg;
    assign status        = status_reg;
    assign element_count = element_count_reg;

endmodule
